>>> sv/qbrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbrs_pkg: shared types and microcode for the quadratic Bezier route sampler
// Control word layout, lane control bundle, step addresses and the program
// ROM that drives the sequencer.
// ----------------------------------------------------------------------------
package qbrs_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int MAX_SAMPLES_DEF = 63;

  // div_count register and d^2 (d <= 63 -> d^2 < 4096)
  localparam int DIV_W = 6;
  localparam int DEN_W = 12;
  localparam logic [DIV_W-1:0] DIV_RESET = 6'd4;
  localparam logic [DEN_W-1:0] DEN_RESET = 12'd16;

  // headroom of the difference terms over a coordinate
  localparam int EXT_BITS = 10;

  localparam int PC_W = 4;

  localparam logic [PC_W-1:0] PC_IDLE   = 4'd0;
  localparam logic [PC_W-1:0] PC_TEST   = 4'd1;
  localparam logic [PC_W-1:0] PC_LAST   = 4'd2;
  localparam logic [PC_W-1:0] PC_MUL    = 4'd3;
  localparam logic [PC_W-1:0] PC_SUM    = 4'd4;
  localparam logic [PC_W-1:0] PC_LOAD   = 4'd5;
  localparam logic [PC_W-1:0] PC_DIV1   = 4'd6;
  localparam logic [PC_W-1:0] PC_KEEP1  = 4'd7;
  localparam logic [PC_W-1:0] PC_DIV2   = 4'd8;
  localparam logic [PC_W-1:0] PC_KEEP2  = 4'd9;
  localparam logic [PC_W-1:0] PC_SAMPLE = 4'd10;
  localparam logic [PC_W-1:0] PC_CLOSE  = 4'd11;
  localparam logic [PC_W-1:0] PC_LEN    = 4'd12;

  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_IN,
    HOLD_OUT
  } qbrs_hold_e;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_SEG,
    COND_NOTLAST,
    COND_DIV_MORE,
    COND_MORE
  } qbrs_cond_e;

  typedef struct packed {
    qbrs_hold_e      hold;
    logic            take;
    logic            mul;
    logic            sum;
    logic            load1;
    logic            step;
    logic            keep1;
    logic            keep2;
    logic            advance;
    logic            emit_node;
    logic            close;
    qbrs_cond_e      cond;
    logic [PC_W-1:0] target;
  } qbrs_uop_t;

  typedef struct packed {
    logic take;
    logic set_anchor;
    logic set_control;
    logic mul;
    logic sum;
    logic div_load1;
    logic div_step;
    logic keep1;
    logic keep2;
    logic advance;
    logic close;
  } qbrs_lane_ctl_t;

  function automatic qbrs_uop_t qbrs_rom(input logic [PC_W-1:0] pc);
    qbrs_uop_t u;
    u = '0;
    u.hold = HOLD_NONE;
    u.cond = COND_NEXT;
    unique case (pc)
      PC_IDLE: begin
        u.hold   = HOLD_IN;
        u.take   = 1'b1;
        u.cond   = COND_SEG;
        u.target = PC_MUL;
      end
      PC_TEST: begin
        u.cond   = COND_NOTLAST;
        u.target = PC_IDLE;
      end
      PC_LAST: begin
        u.hold      = HOLD_OUT;
        u.emit_node = 1'b1;
        u.cond      = COND_ALWAYS;
        u.target    = PC_IDLE;
      end
      PC_MUL:   u.mul   = 1'b1;
      PC_SUM:   u.sum   = 1'b1;
      PC_LOAD:  u.load1 = 1'b1;
      PC_DIV1: begin
        u.step   = 1'b1;
        u.cond   = COND_DIV_MORE;
        u.target = PC_DIV1;
      end
      PC_KEEP1: u.keep1 = 1'b1;
      PC_DIV2: begin
        u.step   = 1'b1;
        u.cond   = COND_DIV_MORE;
        u.target = PC_DIV2;
      end
      PC_KEEP2: u.keep2 = 1'b1;
      PC_SAMPLE: begin
        u.hold    = HOLD_OUT;
        u.advance = 1'b1;
        u.cond    = COND_MORE;
        u.target  = PC_SAMPLE;
      end
      PC_CLOSE: begin
        u.close  = 1'b1;
        u.cond   = COND_ALWAYS;
        u.target = PC_TEST;
      end
      default: begin
        u.cond   = COND_ALWAYS;
        u.target = PC_IDLE;
      end
    endcase
    return u;
  endfunction

endpackage

>>> sv/quadratic_bezier_route_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_bezier_route_sampler: route nodes in, Bezier samples out
// Microcoded sequencer over three coordinate lanes. Every second node after
// the first closes a quadratic segment and yields d rounded samples.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | beat
//  node    | in        | node_valid_i/ready_o    | node_x/y/z_i, node_last_i
//  point   | out       | point_valid_o/ready_i   | point_x/y/z_o, point_last_o
//  cfg     | in        | cfg_valid_i/ready_o     | cfg_div_count_i
//
//  Anchor or control node: stored; one marked last is also sent out as a
//  final point beat. Closing node: the bit-serial divider takes the two
//  difference terms per lane by d^2; samples then leave one per cycle from
//  the difference accumulators while the point channel is not stalled.
//  Reset: waits for the first node of a route, div_count = 4.
//  A stalled point channel freezes the sequencer on its output step.
// ----------------------------------------------------------------------------
module quadratic_bezier_route_sampler #(
  parameter int COORD_WIDTH = qbrs_pkg::COORD_WIDTH_DEF,
  parameter int MAX_SAMPLES = qbrs_pkg::MAX_SAMPLES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [qbrs_pkg::DIV_W-1:0]    cfg_div_count_i,
  input  logic                          node_valid_i,
  output logic                          node_ready_o,
  input  logic signed [COORD_WIDTH-1:0] node_x_i,
  input  logic signed [COORD_WIDTH-1:0] node_y_i,
  input  logic signed [COORD_WIDTH-1:0] node_z_i,
  input  logic                          node_last_i,
  output logic                          point_valid_o,
  input  logic                          point_ready_i,
  output logic signed [COORD_WIDTH-1:0] point_x_o,
  output logic signed [COORD_WIDTH-1:0] point_y_o,
  output logic signed [COORD_WIDTH-1:0] point_z_o,
  output logic                          point_last_o
);

  localparam int EW    = COORD_WIDTH + qbrs_pkg::EXT_BITS;
  localparam int CNT_W = $clog2(EW + 1);
  localparam int DIV_W = qbrs_pkg::DIV_W;
  localparam int DEN_W = qbrs_pkg::DEN_W;
  localparam int PC_W  = qbrs_pkg::PC_W;

  typedef enum logic [1:0] {
    PH_FIRST   = 2'd0,
    PH_CONTROL = 2'd1,
    PH_CLOSE   = 2'd2
  } phase_e;

  logic [PC_W-1:0]        pc_q, pc_d;
  phase_e                 phase_q;
  logic [CNT_W-1:0]       div_cnt_q;
  logic [DIV_W-1:0]       j_q;
  logic [DIV_W-1:0]       cfg_q;
  logic [DEN_W-1:0]       den_q;
  logic                   last_q;
  logic                   point_valid_q;
  logic [COORD_WIDTH-1:0] point_x_q, point_y_q, point_z_q;
  logic                   point_last_q;

  qbrs_pkg::qbrs_uop_t      uop;
  qbrs_pkg::qbrs_lane_ctl_t lane_ctl;
  logic                     go, jump, out_free;
  logic                     load_sample, load_node;
  logic [DIV_W-1:0]         d_eff;

  logic [COORD_WIDTH-1:0] lane_in     [3];
  logic [COORD_WIDTH-1:0] lane_sample [3];
  logic [COORD_WIDTH-1:0] lane_node   [3];

  // zero acts as one, anything above the limit as the limit
  always_comb begin
    if (cfg_q == '0) begin
      d_eff = DIV_W'(1);
    end else if (cfg_q > DIV_W'(MAX_SAMPLES)) begin
      d_eff = DIV_W'(MAX_SAMPLES);
    end else begin
      d_eff = cfg_q;
    end
  end

  assign uop      = qbrs_pkg::qbrs_rom(pc_q);
  assign out_free = !point_valid_q || point_ready_i;

  always_comb begin
    unique case (uop.hold)
      qbrs_pkg::HOLD_IN:  go = node_valid_i;
      qbrs_pkg::HOLD_OUT: go = out_free;
      default:            go = 1'b1;
    endcase
  end

  always_comb begin
    unique case (uop.cond)
      qbrs_pkg::COND_ALWAYS:   jump = 1'b1;
      qbrs_pkg::COND_SEG:      jump = (phase_q == PH_CLOSE);
      qbrs_pkg::COND_NOTLAST:  jump = !last_q;
      qbrs_pkg::COND_DIV_MORE: jump = (div_cnt_q != CNT_W'(1));
      qbrs_pkg::COND_MORE:     jump = (j_q != DIV_W'(d_eff - DIV_W'(1)));
      default:                 jump = 1'b0;
    endcase
    if (!go) begin
      pc_d = pc_q;
    end else if (jump) begin
      pc_d = uop.target;
    end else begin
      pc_d = PC_W'(pc_q + PC_W'(1));
    end
  end

  always_comb begin
    lane_ctl             = '0;
    lane_ctl.take        = go && uop.take;
    lane_ctl.set_anchor  = lane_ctl.take && (phase_q != PH_CONTROL) && (phase_q != PH_CLOSE);
    lane_ctl.set_control = lane_ctl.take && (phase_q == PH_CONTROL);
    lane_ctl.mul         = uop.mul;
    lane_ctl.sum         = uop.sum;
    lane_ctl.div_load1   = uop.load1;
    lane_ctl.div_step    = uop.step;
    lane_ctl.keep1       = uop.keep1;
    lane_ctl.keep2       = uop.keep2;
    lane_ctl.advance     = go && uop.advance;
    lane_ctl.close       = uop.close;
  end

  assign load_sample = go && uop.advance;
  assign load_node   = go && uop.emit_node;

  assign lane_in[0] = node_x_i;
  assign lane_in[1] = node_y_i;
  assign lane_in[2] = node_z_i;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    qbrs_lane #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (lane_ctl),
      .div_count_i (d_eff),
      .den_i       (den_q),
      .node_i      ($signed(lane_in[g])),
      .sample_o    (lane_sample[g]),
      .node_o      (lane_node[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q          <= qbrs_pkg::PC_IDLE;
      phase_q       <= PH_FIRST;
      div_cnt_q     <= '0;
      j_q           <= '0;
      cfg_q         <= qbrs_pkg::DIV_RESET;
      den_q         <= qbrs_pkg::DEN_RESET;
      last_q        <= 1'b0;
      point_valid_q <= 1'b0;
      point_x_q     <= '0;
      point_y_q     <= '0;
      point_z_q     <= '0;
      point_last_q  <= 1'b0;
    end else begin
      pc_q  <= pc_d;
      den_q <= DEN_W'({{(DEN_W-DIV_W){1'b0}}, d_eff} * {{(DEN_W-DIV_W){1'b0}}, d_eff});
      if (cfg_valid_i) begin
        cfg_q <= cfg_div_count_i;
      end
      if (lane_ctl.take) begin
        last_q <= node_last_i;
      end

      if (lane_ctl.set_anchor || lane_ctl.close) begin
        phase_q <= PH_CONTROL;
      end else if (lane_ctl.set_control) begin
        phase_q <= PH_CLOSE;
      end else if (load_node) begin
        phase_q <= PH_FIRST;
      end

      if (uop.load1 || uop.keep1) begin
        div_cnt_q <= CNT_W'(EW);
      end else if (uop.step) begin
        div_cnt_q <= CNT_W'(div_cnt_q - CNT_W'(1));
      end

      if (uop.keep2) begin
        j_q <= '0;
      end else if (load_sample) begin
        j_q <= DIV_W'(j_q + DIV_W'(1));
      end

      if (load_sample) begin
        point_valid_q <= 1'b1;
        point_x_q     <= lane_sample[0];
        point_y_q     <= lane_sample[1];
        point_z_q     <= lane_sample[2];
        point_last_q  <= 1'b0;
      end else if (load_node) begin
        point_valid_q <= 1'b1;
        point_x_q     <= lane_node[0];
        point_y_q     <= lane_node[1];
        point_z_q     <= lane_node[2];
        point_last_q  <= 1'b1;
      end else if (point_ready_i) begin
        point_valid_q <= 1'b0;
      end
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign node_ready_o  = (uop.hold == qbrs_pkg::HOLD_IN);
  assign point_valid_o = point_valid_q;
  assign point_x_o     = $signed(point_x_q);
  assign point_y_o     = $signed(point_y_q);
  assign point_z_o     = $signed(point_z_q);
  assign point_last_o  = point_last_q;

`ifndef SYNTHESIS
  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q < qbrs_pkg::PC_LEN)
    else $error("sequencer left the program");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == qbrs_pkg::PC_DIV1 || pc_q == qbrs_pkg::PC_DIV2) |-> div_cnt_q != '0)
    else $error("divider stepped with no bits left");

  a_sample_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q == qbrs_pkg::PC_SAMPLE |-> j_q < d_eff)
    else $error("sample index ran past d");

  a_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    node_valid_i && node_ready_o |=> pc_q == qbrs_pkg::PC_TEST || pc_q == qbrs_pkg::PC_MUL)
    else $error("bad step after node beat");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    point_valid_o && !point_ready_i |-> !load_sample && !load_node)
    else $error("output register overwritten while stalled");
`endif

endmodule

>>> sv/qbrs_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbrs_lane: one coordinate of the sampler
// Holds anchor, control and closing node, forms the first and second
// differences of the numerator, splits them by d^2 with a bit-serial divider
// and steps quotient/remainder accumulators one sample at a time.
// ----------------------------------------------------------------------------
module qbrs_lane #(
  parameter int COORD_WIDTH = qbrs_pkg::COORD_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  qbrs_pkg::qbrs_lane_ctl_t           ctl_i,
  input  logic [qbrs_pkg::DIV_W-1:0]         div_count_i,
  input  logic [qbrs_pkg::DEN_W-1:0]         den_i,
  input  logic signed [COORD_WIDTH-1:0]      node_i,
  output logic [COORD_WIDTH-1:0]             sample_o,
  output logic [COORD_WIDTH-1:0]             node_o
);

  localparam int EW   = COORD_WIDTH + qbrs_pkg::EXT_BITS;
  localparam int DW   = qbrs_pkg::DEN_W;
  localparam int CF_W = qbrs_pkg::DIV_W + 2;
  localparam int PW   = COORD_WIDTH + CF_W;

  logic signed [COORD_WIDTH-1:0] anchor_q, control_q, node_q;
  logic signed [PW-1:0]          prod_a_q, prod_c_q;
  logic signed [EW-1:0]          x1_q, x2_q;
  logic [EW-1:0]                 div_quo_q;
  logic [DW-1:0]                 div_rem_q;
  logic                          div_neg_q;
  logic signed [EW-1:0]          p_q, u_q, q_q;
  logic [DW-1:0]                 s_q, v_q, r_q;

  logic signed [CF_W-1:0] twice_d, coef_a, coef_c;
  logic signed [EW-1:0]   x1_d, x2_d, div_src;
  logic [DW:0]            rem_sh, rem_sub;
  logic                   fits;
  logic [EW-1:0]          quo_res;
  logic [DW-1:0]          rem_res;
  logic [DW:0]            r_sum, s_sum;
  logic                   carry_r, carry_s;
  logic [DW-1:0]          r_nx, s_nx;

  // A*(1-2d) + C*(2d-2) + B is the first difference, 2(A-2C+B) the second
  always_comb begin
    twice_d = $signed({1'b0, div_count_i, 1'b0});
    coef_a  = CF_W'(1) - twice_d;
    coef_c  = twice_d - CF_W'(2);
    x1_d    = EW'(prod_a_q) + EW'(prod_c_q) + EW'(node_q);
    x2_d    = (EW'(anchor_q) + EW'(node_q) - (EW'(control_q) <<< 1)) <<< 1;
    div_src = ctl_i.div_load1 ? x1_q : x2_q;
  end

  // restoring divider on |x| (ones' complement for negatives gives floor)
  always_comb begin
    rem_sh  = {div_rem_q, div_quo_q[EW-1]};
    fits    = rem_sh >= {1'b0, den_i};
    rem_sub = rem_sh - {1'b0, den_i};
    quo_res = div_neg_q ? ~div_quo_q : div_quo_q;
    rem_res = div_neg_q ? (den_i - DW'(1) - div_rem_q) : div_rem_q;
  end

  always_comb begin
    r_sum   = {1'b0, r_q} + {1'b0, s_q};
    carry_r = r_sum >= {1'b0, den_i};
    r_nx    = carry_r ? DW'(r_sum - {1'b0, den_i}) : r_sum[DW-1:0];
    s_sum   = {1'b0, s_q} + {1'b0, v_q};
    carry_s = s_sum >= {1'b0, den_i};
    s_nx    = carry_s ? DW'(s_sum - {1'b0, den_i}) : s_sum[DW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anchor_q  <= '0;
      control_q <= '0;
    end else begin
      if (ctl_i.set_anchor) begin
        anchor_q <= node_i;
      end else if (ctl_i.close) begin
        anchor_q <= node_q;
      end
      if (ctl_i.set_control) begin
        control_q <= node_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.take) begin
      node_q <= node_i;
    end
    if (ctl_i.mul) begin
      prod_a_q <= anchor_q * coef_a;
      prod_c_q <= control_q * coef_c;
    end
    if (ctl_i.sum) begin
      x1_q <= x1_d;
      x2_q <= x2_d;
    end
    if (ctl_i.div_load1 || ctl_i.keep1) begin
      div_neg_q <= div_src[EW-1];
      div_quo_q <= div_src[EW-1] ? ~div_src : div_src;
      div_rem_q <= '0;
    end else if (ctl_i.div_step) begin
      div_quo_q <= {div_quo_q[EW-2:0], fits};
      div_rem_q <= fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
    end
    if (ctl_i.keep1) begin
      p_q <= quo_res;
      s_q <= rem_res;
    end
    if (ctl_i.keep2) begin
      u_q <= quo_res;
      v_q <= rem_res;
      q_q <= EW'(anchor_q);
      r_q <= den_i >> 1;
    end else if (ctl_i.advance) begin
      q_q <= q_q + p_q + EW'(carry_r);
      r_q <= r_nx;
      p_q <= p_q + u_q + EW'(carry_s);
      s_q <= s_nx;
    end
  end

  assign sample_o = q_q[COORD_WIDTH-1:0];
  assign node_o   = node_q;

endmodule
